>>> hw/rtl/cia_pkg.sv
// shared types and constants for the checked integer alu
// no dependencies
package cia_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ShamtW  = 5;
  localparam int unsigned DivStages = DataW;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_SHL  = 4'd5,
    OP_SHR  = 4'd6,
    OP_AND  = 4'd7,
    OP_OR   = 4'd8,
    OP_XOR  = 4'd9,
    OP_ROTL = 4'd10,
    OP_ROTR = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_DIVZERO  = 2'd2,
    ERR_SHIFT    = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    KIND_FAST = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2,
    KIND_MOD  = 2'd3
  } kind_e;

  // result info that rides along the divider array
  typedef struct packed {
    logic [DataW-1:0] val;
    err_e             err;
    kind_e            kind;
    logic             neg_q;
    logic             neg_r;
  } side_t;

  // one stage of the divider array
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] den;
    side_t            side;
  } div_t;

endpackage

>>> hw/rtl/cia_if.sv
// valid/ready channel interfaces for requests and responses
// depends on cia_pkg
interface cia_req_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  req_type;
  logic [cia_pkg::DataW-1:0]   operand_a;
  logic [cia_pkg::DataW-1:0]   operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface cia_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cia_pkg::DataW-1:0]   result_value;
  logic [1:0]                  error_kind;
  modport source (output valid, result_value, error_kind, input ready);
  modport sink (input valid, result_value, error_kind, output ready);
endinterface

>>> hw/rtl/cia_front.sv
// front stages: fast operations, signed multiply, divider operand setup
// depends on cia_pkg
module cia_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [3:0]                op_i,
  input  logic [cia_pkg::DataW-1:0] a_i,
  input  logic [cia_pkg::DataW-1:0] b_i,
  output logic                      valid_o,
  output cia_pkg::div_t             div_o
);
  import cia_pkg::*;

  logic [DataW:0]     sum, diff;
  logic [2*DataW-1:0] rot_l, rot_r;
  logic [ShamtW-1:0]  amt;
  logic               b_big;
  side_t              side_d;
  logic [2*DataW-1:0] prod_d;
  logic [DataW-1:0]   da_d, db_d;

  side_t              side2_q;
  logic [2*DataW-1:0] prod_q;
  logic [DataW-1:0]   da_q, db_q;
  logic               valid2_q, valid3_q;
  div_t               div3_q;
  side_t              side3;
  logic               mul_ovf;

  assign sum   = {a_i[DataW-1], a_i} + {b_i[DataW-1], b_i};
  assign diff  = {a_i[DataW-1], a_i} - {b_i[DataW-1], b_i};
  assign amt   = b_i[ShamtW-1:0];
  assign b_big = |b_i[DataW-1:ShamtW];
  assign rot_l = {a_i, a_i} << amt;
  assign rot_r = {a_i, a_i} >> amt;

  always_comb begin
    side_d       = '0;
    side_d.err   = ERR_NONE;
    side_d.kind  = KIND_FAST;
    side_d.neg_q = a_i[DataW-1] ^ b_i[DataW-1];
    side_d.neg_r = a_i[DataW-1];
    prod_d = $signed(a_i) * $signed(b_i);
    da_d = a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
    db_d = b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
    unique case (op_e'(op_i))
      OP_ADD:  begin
        side_d.val = sum[DataW-1:0];
        if (sum[DataW] != sum[DataW-1]) side_d.err = ERR_OVERFLOW;
      end
      OP_SUB:  begin
        side_d.val = diff[DataW-1:0];
        if (diff[DataW] != diff[DataW-1]) side_d.err = ERR_OVERFLOW;
      end
      OP_MUL:  side_d.kind = KIND_MUL;
      OP_DIV, OP_MOD: begin
        side_d.kind = (op_e'(op_i) == OP_DIV) ? KIND_DIV : KIND_MOD;
        if (b_i == '0) begin
          side_d.err = ERR_DIVZERO;
        end else if (a_i == {1'b1, {(DataW-1){1'b0}}} && b_i == '1) begin
          side_d.err = ERR_OVERFLOW;
        end
      end
      OP_SHL:  begin
        if (b_big) side_d.err = ERR_SHIFT;
        else side_d.val = a_i << amt;
      end
      OP_SHR:  begin
        if (b_big) side_d.err = ERR_SHIFT;
        else side_d.val = a_i >> amt;
      end
      OP_AND:  side_d.val = a_i & b_i;
      OP_OR:   side_d.val = a_i | b_i;
      OP_XOR:  side_d.val = a_i ^ b_i;
      OP_ROTL: side_d.val = rot_l[2*DataW-1:DataW];
      OP_ROTR: side_d.val = rot_r[DataW-1:0];
      default: side_d.val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side_d;
      prod_q  <= prod_d;
      da_q    <= da_d;
      db_q    <= db_d;
    end
  end

  // product fits when its upper half matches the sign of the lower half
  assign mul_ovf = (prod_q[2*DataW-1:DataW-1] != '0) && (prod_q[2*DataW-1:DataW-1] != '1);

  always_comb begin
    side3 = side2_q;
    if (side2_q.kind == KIND_MUL) begin
      side3.val = prod_q[DataW-1:0];
      if (mul_ovf) side3.err = ERR_OVERFLOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div3_q.rem  <= '0;
      div3_q.quo  <= da_q;
      div3_q.den  <= db_q;
      div3_q.side <= side3;
    end
  end

  assign valid_o = valid3_q;
  assign div_o   = div3_q;

endmodule

>>> hw/rtl/cia_divider.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on cia_pkg
module cia_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cia_pkg::div_t div_i,
  output logic          valid_o,
  output cia_pkg::div_t div_o
);
  import cia_pkg::*;

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    logic [DataW:0] trial;
    div_t           cur;
    logic           cur_valid;
    div_t           nxt;
    div_t           st_q;
    logic           valid_q;

    if (i == 0) begin : g_head
      assign cur       = div_i;
      assign cur_valid = valid_i;
    end else begin : g_link
      assign cur       = g_stage[i-1].st_q;
      assign cur_valid = g_stage[i-1].valid_q;
    end

    assign trial = {cur.rem, cur.quo[DataW-1]} - {1'b0, cur.den};

    always_comb begin
      nxt = cur;
      if (!trial[DataW]) begin
        nxt.rem = trial[DataW-1:0];
        nxt.quo = {cur.quo[DataW-2:0], 1'b1};
      end else begin
        nxt.rem = {cur.rem[DataW-2:0], cur.quo[DataW-1]};
        nxt.quo = {cur.quo[DataW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= cur_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q <= nxt;
    end
  end

  assign valid_o = g_stage[DivStages-1].valid_q;
  assign div_o   = g_stage[DivStages-1].st_q;

endmodule

>>> hw/rtl/checked_integer_alu_top.sv
// top level of the checked integer alu: input register, front, divider, output stage
// depends on cia_pkg, cia_if, cia_front, cia_divider
// throughput: one transaction per cycle while the response is not stalled;
// every stage is registered and fully pipelined
// a stalled response holds the whole pipeline in place
// reset clears all valid bits; payload registers are not reset
module checked_integer_alu_top (
  input  logic clk_i,
  input  logic rst_ni,
  cia_req_if.sink   req_i,
  cia_rsp_if.source rsp_o
);
  import cia_pkg::*;

  logic             en;
  logic             in_valid_q;
  logic [3:0]       op_q;
  logic [DataW-1:0] a_q, b_q;
  logic             f_valid, d_valid;
  div_t             f_div, d_div;
  logic             out_valid_q;
  logic [DataW-1:0] out_val_q;
  err_e             out_err_q;
  logic [DataW-1:0] val_d;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q  <= req_i.valid;
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= req_i.req_type;
      a_q  <= req_i.operand_a;
      b_q  <= req_i.operand_b;
    end
  end

  cia_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .op_i    (op_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .valid_o (f_valid),
    .div_o   (f_div)
  );

  cia_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .div_i   (f_div),
    .valid_o (d_valid),
    .div_o   (d_div)
  );

  always_comb begin
    unique case (d_div.side.kind)
      KIND_DIV: val_d = d_div.side.neg_q ? (~d_div.quo + 1'b1) : d_div.quo;
      KIND_MOD: val_d = d_div.side.neg_r ? (~d_div.rem + 1'b1) : d_div.rem;
      default:  val_d = d_div.side.val;
    endcase
    if (d_div.side.err != ERR_NONE) val_d = {{(DataW-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q <= val_d;
      out_err_q <= d_div.side.err;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_val_q;
  assign rsp_o.error_kind   = out_err_q;

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.error_kind != ERR_NONE) |-> (rsp_o.result_value == 1))
    else $error("error response without value one");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while response stalled");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && !en) |=> d_valid)
    else $error("divider output lost during stall");

endmodule
